// ----- rtl/srf_pkg.sv -----
// Shared constants for the surrounded region fill block.
package srf_pkg;

    // Default grid bounds
    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS_DEF = 8;

    // Configuration port shape
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Width of the emitted row and column fields
    localparam int COORD_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] GRID_ROWS_RST = CFG_DATA_W'(8);
    localparam logic [CFG_DATA_W-1:0] GRID_COLS_RST = CFG_DATA_W'(8);

endpackage

// ----- rtl/surrounded_region_fill.sv -----
// Binary hole filling by a queue-driven 4-connected flood, top level.
//
//   Channel  | Ports                                   | Direction | Handshake
//   ---------+-----------------------------------------+-----------+----------------------
//   config   | i_cfg_we, i_cfg_index, i_cfg_data       | in        | write when i_cfg_we
//   cells    | i_in_valid, o_in_stall, i_cell_open     | in        | beat on valid & !stall
//   result   | o_out_valid, i_out_stall, o_result_open,| out       | beat on valid & !stall
//            | o_row_index, o_col_index, o_last_cell   |           |
//
// Cells load at one per cycle. After the last cell the sequencer clears each entry of
// the visited store, scans the grid (read, then check each cell), pops each queued
// cell (read, then take) and probes its four neighbours, checking those in the grid,
// and erases each cell of an enclosed region (read, then write); every step uses the
// single read port of each store. The grid is then emitted cell by cell: read, load, hold.
// Reset is synchronous; no clearing pass follows it, as each flood starts with its own.
// A result stall holds the beat; cells are stalled from the last cell until the final
// result beat has gone.
module surrounded_region_fill #(
    parameter int MAX_ROWS = srf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = srf_pkg::MAX_COLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [srf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cell_open,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_result_open,
    output logic [srf_pkg::COORD_W-1:0]     o_row_index,
    output logic [srf_pkg::COORD_W-1:0]     o_col_index,
    output logic                            o_last_cell
);

    import srf_pkg::*;

    localparam int CELL_TOTAL = MAX_ROWS * MAX_COLS;
    localparam int AW  = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ERW = RIW + 1;
    localparam int ECW = CIW + 1;
    localparam int QW  = RIW + CIW;
    localparam int QCW = $clog2(CELL_TOTAL + 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(CELL_TOTAL - 1);

    // Neighbour order of the flood
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [12:0] {
        S_LOAD     = 13'h0001,
        S_CLEAR    = 13'h0002,
        S_SCAN_RD  = 13'h0004,
        S_SCAN_CHK = 13'h0008,
        S_POP_RD   = 13'h0010,
        S_POP_CHK  = 13'h0020,
        S_NB_RD    = 13'h0040,
        S_NB_CHK   = 13'h0080,
        S_ERASE_RD = 13'h0100,
        S_ERASE_WR = 13'h0200,
        S_OUT_RD   = 13'h0400,
        S_OUT_LD   = 13'h0800,
        S_OUT_HOLD = 13'h1000
    } t_state;

    // Clamp a dimension register to 1..MAX_ROWS
    function automatic logic [ERW-1:0] eff_rows(input logic [CFG_DATA_W-1:0] v);
        int n;
        n = int'(v);
        if (n == 0) n = 1;
        if (n > MAX_ROWS) n = MAX_ROWS;
        return ERW'(n);
    endfunction

    // Clamp a dimension register to 1..MAX_COLS
    function automatic logic [ECW-1:0] eff_cols(input logic [CFG_DATA_W-1:0] v);
        int n;
        n = int'(v);
        if (n == 0) n = 1;
        if (n > MAX_COLS) n = MAX_COLS;
        return ECW'(n);
    endfunction

    // Store address of a cell
    function automatic logic [AW-1:0] cell_addr(input logic [RIW-1:0] r,
                                                input logic [CIW-1:0] c);
        return AW'(int'(r) * MAX_COLS + int'(c));
    endfunction

    t_state                r_state, n_state;
    logic [CFG_DATA_W-1:0] r_grid_rows, n_grid_rows;
    logic [CFG_DATA_W-1:0] r_grid_cols, n_grid_cols;
    logic [RIW-1:0]        r_pos_r, n_pos_r;
    logic [CIW-1:0]        r_pos_c, n_pos_c;
    logic [AW-1:0]         r_clear_addr, n_clear_addr;
    logic [QCW-1:0]        r_head, n_head;
    logic [QCW-1:0]        r_tail, n_tail;
    logic [QCW-1:0]        r_erase, n_erase;
    logic [1:0]            r_dir, n_dir;
    logic                  r_touch, n_touch;
    logic                  r_out_valid, n_out_valid;
    logic [RIW-1:0]        r_cur_r, n_cur_r;
    logic [CIW-1:0]        r_cur_c, n_cur_c;
    logic [RIW-1:0]        r_probe_r, n_probe_r;
    logic [CIW-1:0]        r_probe_c, n_probe_c;
    logic                  r_out_open, n_out_open;
    logic [COORD_W-1:0]    r_out_row, n_out_row;
    logic [COORD_W-1:0]    r_out_col, n_out_col;
    logic                  r_out_last, n_out_last;

    logic [ERW-1:0] rows_eff;
    logic [ECW-1:0] cols_eff;
    logic           pos_col_last, pos_last;
    logic [RIW-1:0] pos_step_r;
    logic [CIW-1:0] pos_step_c;
    logic           nb_ok;
    logic [RIW-1:0] nb_r;
    logic [CIW-1:0] nb_c;
    logic [RIW-1:0] q_r;
    logic [CIW-1:0] q_c;
    logic           q_border;
    logic           in_acc;
    logic           node_end, scan_adv;

    logic           open_we, open_wdata, open_rdata;
    logic [AW-1:0]  open_waddr;
    logic           vis_we, vis_wdata, vis_rdata;
    logic [AW-1:0]  vis_waddr;
    logic [AW-1:0]  rd_addr;
    logic           q_we;
    logic [AW-1:0]  q_waddr, q_raddr;
    logic [QW-1:0]  q_wdata, q_rdata;

    // Stores: loaded grid, flood marks, flood queue (also the member list)
    srf_ram #(.WIDTH(1), .DEPTH(CELL_TOTAL)) u_open_ram (
        .i_clk   (i_clk),
        .i_we    (open_we),
        .i_waddr (open_waddr),
        .i_wdata (open_wdata),
        .i_raddr (rd_addr),
        .o_rdata (open_rdata)
    );

    srf_ram #(.WIDTH(1), .DEPTH(CELL_TOTAL)) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (rd_addr),
        .o_rdata (vis_rdata)
    );

    srf_ram #(.WIDTH(QW), .DEPTH(CELL_TOTAL)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    // Grid size and raster walk position
    assign rows_eff     = eff_rows(r_grid_rows);
    assign cols_eff     = eff_cols(r_grid_cols);
    assign pos_col_last = ({1'b0, r_pos_c} + ECW'(1)) == cols_eff;
    assign pos_last     = pos_col_last && (({1'b0, r_pos_r} + ERW'(1)) == rows_eff);
    assign pos_step_c   = pos_col_last ? '0 : r_pos_c + CIW'(1);
    assign pos_step_r   = pos_col_last ? r_pos_r + RIW'(1) : r_pos_r;

    assign in_acc = i_in_valid && !o_in_stall;

    // Popped queue entry and whether it lies on the grid border
    assign q_r      = q_rdata[QW-1:CIW];
    assign q_c      = q_rdata[CIW-1:0];
    assign q_border = (q_r == '0) || (({1'b0, q_r} + ERW'(1)) >= rows_eff) ||
                      (q_c == '0) || (({1'b0, q_c} + ECW'(1)) >= cols_eff);

    // Neighbour under test and whether it lies inside the grid
    always_comb begin
        nb_r  = r_cur_r;
        nb_c  = r_cur_c;
        nb_ok = 1'b0;
        case (r_dir)
            DIR_UP: begin
                nb_ok = (r_cur_r != '0);
                nb_r  = r_cur_r - RIW'(1);
            end
            DIR_LEFT: begin
                nb_ok = (r_cur_c != '0);
                nb_c  = r_cur_c - CIW'(1);
            end
            DIR_DOWN: begin
                nb_ok = ({1'b0, r_cur_r} + ERW'(1)) < rows_eff;
                nb_r  = r_cur_r + RIW'(1);
            end
            default: begin
                nb_ok = ({1'b0, r_cur_c} + ECW'(1)) < cols_eff;
                nb_c  = r_cur_c + CIW'(1);
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_grid_rows  = r_grid_rows;
        n_grid_cols  = r_grid_cols;
        n_pos_r      = r_pos_r;
        n_pos_c      = r_pos_c;
        n_clear_addr = r_clear_addr;
        n_head       = r_head;
        n_tail       = r_tail;
        n_erase      = r_erase;
        n_dir        = r_dir;
        n_touch      = r_touch;
        n_out_valid  = r_out_valid;
        n_cur_r      = r_cur_r;
        n_cur_c      = r_cur_c;
        n_probe_r    = r_probe_r;
        n_probe_c    = r_probe_c;
        n_out_open   = r_out_open;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_out_last   = r_out_last;

        rd_addr    = cell_addr(r_pos_r, r_pos_c);
        open_we    = 1'b0;
        open_waddr = cell_addr(r_pos_r, r_pos_c);
        open_wdata = i_cell_open;
        vis_we     = 1'b0;
        vis_waddr  = cell_addr(r_pos_r, r_pos_c);
        vis_wdata  = 1'b1;
        q_we       = 1'b0;
        q_waddr    = r_tail[AW-1:0];
        q_wdata    = {r_pos_r, r_pos_c};
        q_raddr    = r_head[AW-1:0];
        node_end   = 1'b0;
        scan_adv   = 1'b0;

        case (r_state)
            // Store each cell beat; the last one starts the flood
            S_LOAD: begin
                if (in_acc) begin
                    open_we = 1'b1;
                    if (pos_last) begin
                        n_pos_r      = '0;
                        n_pos_c      = '0;
                        n_clear_addr = '0;
                        n_state      = S_CLEAR;
                    end else begin
                        n_pos_r = pos_step_r;
                        n_pos_c = pos_step_c;
                    end
                end
            end
            // Wipe the visited marks, one entry a cycle
            S_CLEAR: begin
                vis_we       = 1'b1;
                vis_waddr    = r_clear_addr;
                vis_wdata    = 1'b0;
                n_clear_addr = r_clear_addr + AW'(1);
                if (r_clear_addr == ADDR_LAST) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            // Seed a region at an open, unvisited cell
            S_SCAN_CHK: begin
                if (open_rdata && !vis_rdata) begin
                    vis_we  = 1'b1;
                    q_we    = 1'b1;
                    q_waddr = '0;
                    n_head  = '0;
                    n_tail  = QCW'(1);
                    n_touch = 1'b0;
                    n_state = S_POP_RD;
                end else begin
                    scan_adv = 1'b1;
                end
            end
            S_POP_RD: begin
                n_head  = r_head + QCW'(1);
                n_state = S_POP_CHK;
            end
            // Take the popped cell and note a border hit
            S_POP_CHK: begin
                n_cur_r = q_r;
                n_cur_c = q_c;
                n_touch = r_touch || q_border;
                n_dir   = DIR_UP;
                n_state = S_NB_RD;
            end
            // Probe the next neighbour, skip those off the grid
            S_NB_RD: begin
                rd_addr   = cell_addr(nb_r, nb_c);
                n_probe_r = nb_r;
                n_probe_c = nb_c;
                if (nb_ok) begin
                    n_state = S_NB_CHK;
                end else if (r_dir == DIR_RIGHT) begin
                    node_end = 1'b1;
                end else begin
                    n_dir = r_dir + 2'd1;
                end
            end
            // Queue the neighbour if open and not yet visited
            S_NB_CHK: begin
                if (open_rdata && !vis_rdata) begin
                    vis_we    = 1'b1;
                    vis_waddr = cell_addr(r_probe_r, r_probe_c);
                    q_we      = 1'b1;
                    q_wdata   = {r_probe_r, r_probe_c};
                    n_tail    = r_tail + QCW'(1);
                end
                if (r_dir == DIR_RIGHT) begin
                    node_end = 1'b1;
                end else begin
                    n_dir   = r_dir + 2'd1;
                    n_state = S_NB_RD;
                end
            end
            S_ERASE_RD: begin
                q_raddr = r_erase[AW-1:0];
                n_erase = r_erase + QCW'(1);
                n_state = S_ERASE_WR;
            end
            // Close one member of an enclosed region
            S_ERASE_WR: begin
                open_we    = 1'b1;
                open_waddr = cell_addr(q_r, q_c);
                open_wdata = 1'b0;
                if (r_erase == r_tail) begin
                    scan_adv = 1'b1;
                end else begin
                    n_state = S_ERASE_RD;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_LD;
            end
            // Load the result register
            S_OUT_LD: begin
                n_out_valid = 1'b1;
                n_out_open  = open_rdata;
                n_out_row   = COORD_W'(r_pos_r);
                n_out_col   = COORD_W'(r_pos_c);
                n_out_last  = pos_last;
                n_state     = S_OUT_HOLD;
            end
            // Hold the beat until taken
            S_OUT_HOLD: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_pos_r = '0;
                        n_pos_c = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_pos_r = pos_step_r;
                        n_pos_c = pos_step_c;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // Finish a queued cell: pop the next or close out the region
        if (node_end) begin
            if (r_head < n_tail) begin
                n_state = S_POP_RD;
            end else if (!r_touch) begin
                n_erase = '0;
                n_state = S_ERASE_RD;
            end else begin
                scan_adv = 1'b1;
            end
        end

        // Advance the scan, or move on to emission
        if (scan_adv) begin
            if (pos_last) begin
                n_pos_r = '0;
                n_pos_c = '0;
                n_state = S_OUT_RD;
            end else begin
                n_pos_r = pos_step_r;
                n_pos_c = pos_step_c;
                n_state = S_SCAN_RD;
            end
        end

        // Register writes restart loading
        if (i_cfg_we) begin
            if (i_cfg_index == REG_GRID_ROWS) begin
                n_grid_rows = i_cfg_data;
                n_pos_r     = '0;
                n_pos_c     = '0;
            end else if (i_cfg_index == REG_GRID_COLS) begin
                n_grid_cols = i_cfg_data;
                n_pos_r     = '0;
                n_pos_c     = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_grid_rows  <= GRID_ROWS_RST;
            r_grid_cols  <= GRID_COLS_RST;
            r_pos_r      <= '0;
            r_pos_c      <= '0;
            r_clear_addr <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_erase      <= '0;
            r_dir        <= DIR_UP;
            r_touch      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_grid_rows  <= n_grid_rows;
            r_grid_cols  <= n_grid_cols;
            r_pos_r      <= n_pos_r;
            r_pos_c      <= n_pos_c;
            r_clear_addr <= n_clear_addr;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_erase      <= n_erase;
            r_dir        <= n_dir;
            r_touch      <= n_touch;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur_r    <= n_cur_r;
        r_cur_c    <= n_cur_c;
        r_probe_r  <= n_probe_r;
        r_probe_c  <= n_probe_c;
        r_out_open <= n_out_open;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_last <= n_out_last;
    end

    assign o_in_stall    = (r_state != S_LOAD);
    assign o_out_valid   = r_out_valid;
    assign o_result_open = r_out_open;
    assign o_row_index   = r_out_row;
    assign o_col_index   = r_out_col;
    assign o_last_cell   = r_out_last;

endmodule

// ----- rtl/srf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/srf_checker.sv -----
// Port-level assertions for the surrounded region fill block, with its bind.
module srf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_result_open,
    input logic [srf_pkg::COORD_W-1:0] o_row_index,
    input logic [srf_pkg::COORD_W-1:0] o_col_index,
    input logic                        o_last_cell
);

    import srf_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_result_open) && $stable(o_row_index) &&
         $stable(o_col_index) && $stable(o_last_cell)))
        else $error("result beat changed while stalled");

    // No cell is taken while the grid is being emitted
    a_no_load_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("cell input open during emission");

    // Result valid drops after each taken beat
    a_beat_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("result valid did not drop after a beat");

    // The final result beat reopens loading
    a_reload_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_cell) |=> !o_in_stall)
        else $error("loading not resumed after the last cell");

endmodule

bind surrounded_region_fill srf_checker u_srf_checker (.*);

// ----- tb/sv/testbench.sv -----
// Self-checking bench for the surrounded region fill block: grids in, filled grids out.
module testbench;
    import srf_pkg::*;

    localparam int GRID_CELLS = MAX_ROWS_DEF * MAX_COLS_DEF;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic               is_open;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_cell_beat;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  cell_open = 1'b0;
    logic                  out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_result_open;
    logic [COORD_W-1:0]    o_row_index;
    logic [COORD_W-1:0]    o_col_index;
    logic                  o_last_cell;

    // Bench copy of the block's registers and cell store
    logic [CFG_DATA_W-1:0] rows_reg = GRID_ROWS_RST;
    logic [CFG_DATA_W-1:0] cols_reg = GRID_COLS_RST;
    logic [GRID_CELLS-1:0] cell_store = '0;
    int unsigned           load_pos = 0;

    t_cell_beat filled_q[$];
    bit         pending_cells[$];
    int         errors = 0;
    t_idle_mode idle_mode = IDLE_NONE;

    surrounded_region_fill dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_cell_open   (cell_open),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_result_open (o_result_open),
        .o_row_index   (o_row_index),
        .o_col_index   (o_col_index),
        .o_last_cell   (o_last_cell)
    );

    always #5 i_clk = ~i_clk;

    // Clamp a dimension register to the range the block uses
    function automatic int unsigned dim_in_use(logic [CFG_DATA_W-1:0] raw, int unsigned max_dim);
        if (raw == 0) return 1;
        if (raw > max_dim) return max_dim;
        return 32'(raw);
    endfunction

    function automatic bit coin(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic bit sender_holds();
        case (idle_mode)
            IDLE_SENDER: return coin(81);
            IDLE_BOTH:   return coin(13);
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_holds();
        case (idle_mode)
            IDLE_RECEIVER: return coin(81);
            IDLE_BOTH:     return coin(13);
            default:       return 1'b0;
        endcase
    endfunction

    function automatic void note_failure(string what);
        errors++;
        if (errors <= 10) $display("[%0t] %s", $realtime, what);
    endfunction

    // Append one cell to the send queue
    function automatic void add_cell(bit v);
        pending_cells.insert(pending_cells.size(), v);
    endfunction

    // Append one expected result beat
    function automatic void add_beat(t_cell_beat b);
        filled_q.insert(filled_q.size(), b);
    endfunction

    // Keep open only cells 4-connected to an open border cell, then queue the grid in raster order
    function automatic void emit_filled_grid(int unsigned rows, int unsigned cols);
        logic [GRID_CELLS-1:0] reach;
        bit                    grew;
        int unsigned           k;
        t_cell_beat            beat;
        reach = '0;
        for (int unsigned r = 0; r < rows; r++) begin
            for (int unsigned c = 0; c < cols; c++) begin
                k = r * MAX_COLS_DEF + c;
                if (cell_store[k] && (r == 0 || r == rows - 1 || c == 0 || c == cols - 1))
                    reach[k] = 1'b1;
            end
        end
        do begin
            grew = 1'b0;
            for (int unsigned r = 0; r < rows; r++) begin
                for (int unsigned c = 0; c < cols; c++) begin
                    k = r * MAX_COLS_DEF + c;
                    if (cell_store[k] && !reach[k] &&
                        ((r > 0 && reach[k - MAX_COLS_DEF]) || (c > 0 && reach[k - 1]) ||
                         (r + 1 < rows && reach[k + MAX_COLS_DEF]) ||
                         (c + 1 < cols && reach[k + 1]))) begin
                        reach[k] = 1'b1;
                        grew = 1'b1;
                    end
                end
            end
        end while (grew);
        for (int unsigned r = 0; r < rows; r++) begin
            for (int unsigned c = 0; c < cols; c++) begin
                beat = '{reach[r * MAX_COLS_DEF + c], COORD_W'(r), COORD_W'(c),
                         (r == rows - 1 && c == cols - 1)};
                add_beat(beat);
            end
        end
    endfunction

    // Store one accepted cell; the grid's last cell triggers the fill
    function automatic void load_cell(logic v);
        int unsigned rows;
        int unsigned cols;
        rows = dim_in_use(rows_reg, MAX_ROWS_DEF);
        cols = dim_in_use(cols_reg, MAX_COLS_DEF);
        if (load_pos >= rows * cols) load_pos = 0;
        cell_store[(load_pos / cols) * MAX_COLS_DEF + load_pos % cols] = v;
        load_pos++;
        if (load_pos == rows * cols) begin
            emit_filled_grid(rows, cols);
            load_pos = 0;
        end
    endfunction

    function automatic void check_beat();
        t_cell_beat got;
        t_cell_beat want;
        got = '{o_result_open, o_row_index, o_col_index, o_last_cell};
        if (filled_q.size() == 0) begin
            note_failure($sformatf("unexpected beat open=%0b row=%0d col=%0d last=%0b",
                                   got.is_open, got.row, got.col, got.last));
            return;
        end
        want = filled_q.pop_front();
        if (got.is_open !== want.is_open || got.row !== want.row ||
            got.col !== want.col || got.last !== want.last)
            note_failure($sformatf({"mismatch expected open=%0b row=%0d col=%0d last=%0b, ",
                                    "got open=%0b row=%0d col=%0d last=%0b"},
                                   want.is_open, want.row, want.col, want.last,
                                   got.is_open, got.row, got.col, got.last));
    endfunction

    // Cell driver: hold a stalled beat, otherwise present the next cell or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) load_cell(cell_open);
            if (!in_valid || !o_in_stall) begin
                if (pending_cells.size() != 0 && !sender_holds()) begin
                    in_valid  <= 1'b1;
                    cell_open <= pending_cells.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each beat and pick the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) check_beat();
            out_stall <= receiver_holds();
        end
    end

    // Sample the idle condition mid-cycle, clear of the edge updates
    task automatic wait_idle();
        while (pending_cells.size() != 0 || in_valid || filled_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_GRID_ROWS) begin
            rows_reg = val;
            load_pos = 0;
        end else if (idx == REG_GRID_COLS) begin
            cols_reg = val;
            load_pos = 0;
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random_grid(int unsigned cells);
        int unsigned density;
        density = $urandom_range(25, 90);
        repeat (cells) add_cell(coin(density));
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] rows_raw;
        logic [CFG_DATA_W-1:0] cols_raw;
        int unsigned           phase_cells;
        int unsigned           grid_size;
        int unsigned           drain;
        logic [7:0]            col_bits;
        logic [8:0]            hole_bits;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero dimensions fall back to a single cell
        write_reg(REG_GRID_ROWS, 4'd0);
        write_reg(REG_GRID_COLS, 4'd0);
        add_cell(1'b1);
        add_cell(1'b0);
        wait_idle();

        // Oversized row count saturates: an 8 by 1 column, all border
        write_reg(REG_GRID_ROWS, 4'd15);
        write_reg(REG_GRID_COLS, 4'd1);
        col_bits = 8'b1100_1011;
        for (int k = 0; k < 8; k++) add_cell(col_bits[k]);
        wait_idle();

        // Partial load dropped by a register write, unknown indexes ignored, then an enclosed hole
        write_reg(REG_GRID_ROWS, 4'd3);
        write_reg(REG_GRID_COLS, 4'd3);
        add_cell(1'b1);
        add_cell(1'b1);
        wait_idle();
        write_reg(REG_GRID_COLS, 4'd3);
        write_reg(CFG_IDX_W'(2), 4'hF);
        write_reg(CFG_IDX_W'(3), 4'h5);
        hole_bits = 9'b000_010_000;
        for (int k = 0; k < 9; k++) add_cell(hole_bits[8 - k]);
        wait_idle();

        // Random grids over the four idling phases, mostly small
        for (int ph = 0; ph < 4; ph++) begin
            idle_mode   = t_idle_mode'(ph);
            phase_cells = 0;
            while (phase_cells < 5) begin
                wait_idle();
                if (ph == 0 && phase_cells == 0) begin
                    rows_raw = 4'd8;
                    cols_raw = 4'd8;
                end else begin
                    rows_raw = coin(12) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 5));
                    cols_raw = coin(12) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 5));
                end
                write_reg(REG_GRID_ROWS, rows_raw);
                write_reg(REG_GRID_COLS, cols_raw);
                if (coin(20)) write_reg(CFG_IDX_W'($urandom_range(2, 3)), 4'($urandom));
                grid_size = dim_in_use(rows_raw, MAX_ROWS_DEF) * dim_in_use(cols_raw, MAX_COLS_DEF);
                repeat ((grid_size > 16) ? 1 : $urandom_range(1, 3)) begin
                    queue_random_grid(grid_size);
                    phase_cells += grid_size;
                end
            end
        end

        // Drain, then watch for stray beats
        drain = 0;
        while ((pending_cells.size() != 0 || in_valid || filled_q.size() != 0) && drain < 50000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (200) @(posedge i_clk);
        if (filled_q.size() != 0)
            note_failure($sformatf("%0d expected beats never arrived", filled_q.size()));
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/srf_pkg.sv
rtl/srf_ram.sv
rtl/surrounded_region_fill.sv
rtl/srf_checker.sv
tb/sv/testbench.sv
